// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cbc_pkg.sv -----
// types, constants and helpers of the cartridge bank controller
package cbc_pkg;

    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ROM_READ  = 3'd1,
        TGT_RAM_READ  = 3'd2,
        TGT_RAM_WRITE = 3'd3,
        TGT_CONTROL   = 3'd4
    } target_t;

    localparam logic [15:0] ROM_WIN_LO  = 16'h4000;
    localparam logic [15:0] ROM_WIN_HI  = 16'h7FFF;
    localparam logic [15:0] RAM_WIN_LO  = 16'hA000;
    localparam logic [15:0] RAM_WIN_HI  = 16'hBFFF;
    localparam logic [15:0] CTRL_STRIDE = 16'h2000;
    localparam logic [3:0]  RAM_EN_KEY  = 4'hA;

    typedef struct packed {
        logic [6:0] rom_bank;
        logic [1:0] ram_bank;
        logic       ram_mode;
        logic       ram_enable;
    } cbc_state_t;

    typedef struct packed {
        logic        handled;
        target_t     target;
        logic [20:0] mapped_address;
        logic [7:0]  ram_data_out;
        logic        ram_enable_flag;
    } cbc_result_t;

    // banks 0x00, 0x20, 0x40, 0x60 step to the next bank
    function automatic logic [6:0] adjust_bank(input logic [6:0] b);
        logic [6:0] r;
        r = b;
        if (b[4:0] == 5'd0)
        begin
            r[0] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/cbc_channels.sv -----
// valid/ready channel interfaces for bus accesses and translated results
interface cbc_access_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface cbc_result_if;
    logic        valid;
    logic        ready;
    logic        handled;
    logic [2:0]  target;
    logic [20:0] mapped_address;
    logic [7:0]  ram_data_out;
    logic        ram_enable_flag;

    modport source (output valid, handled, target, mapped_address, ram_data_out,
                    ram_enable_flag, input ready);
    modport sink   (input valid, handled, target, mapped_address, ram_data_out,
                    ram_enable_flag, output ready);
endinterface

// ----- rtl/cartridge_bank_controller.sv -----
// top level: bus access in, translated cartridge access out
// an accepted access passes through the input register and then the result register to the output
// throughput: one access per cycle when not stalled; set by the input to result register pass
// a stalled result holds in the result register; an empty input register takes one more transfer
// reset clears both valid flags; rom bank resets to 1, ram bank, mode and enable latch to 0
`include "assert_macros.svh"

module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    cbc_access_if.sink          access,
    cbc_result_if.source        result
);

    // input register stage
    logic        s1_valid_reg;
    logic        s1_command_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_write_data_reg;

    // result register stage
    logic        out_valid_reg;
    cbc_result_t out_result_reg;

    cbc_state_t  state;
    cbc_state_t  state_next;
    cbc_result_t result_next;

    logic advance;
    logic s1_fire;
    logic in_fire;

    // result stage can take a new value when empty or when its transfer completes
    assign advance = !out_valid_reg || result.ready;
    assign s1_fire = s1_valid_reg && advance;
    assign access.ready = !s1_valid_reg || advance;
    assign in_fire = access.valid && access.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (access.ready)
        begin
            s1_valid_reg <= access.valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_command_reg    <= access.command;
            s1_address_reg    <= access.address;
            s1_write_data_reg <= access.write_data;
        end
    end

    // decode and translate against the current banking state
    cbc_translate u_translate (
        .command    (s1_command_reg),
        .address    (s1_address_reg),
        .write_data (s1_write_data_reg),
        .state      (state),
        .state_next (state_next),
        .result     (result_next)
    );

    // bank state commits when the access moves into the result register
    cbc_bank_regs u_bank_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_fire),
        .state_next (state_next),
        .state      (state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.handled         = out_result_reg.handled;
    assign result.target          = out_result_reg.target;
    assign result.mapped_address  = out_result_reg.mapped_address;
    assign result.ram_data_out    = out_result_reg.ram_data_out;
    assign result.ram_enable_flag = out_result_reg.ram_enable_flag;

    // rom bank never lands on a bank whose low five bits are zero
    `CBC_ASSERT_IMP(a_rom_bank_adjusted, clk, rst_n, 1'b1, state.rom_bank[4:0] != 5'd0,
        "rom bank low bits are zero")

    // handled flag agrees with the target code
    `CBC_ASSERT_IMP(a_handled_target, clk, rst_n, out_valid_reg,
        out_result_reg.handled == (out_result_reg.target != TGT_NONE),
        "handled flag disagrees with target")

    // ram translations stay inside the four ram banks
    `CBC_ASSERT_IMP(a_ram_range, clk, rst_n,
        out_valid_reg && (out_result_reg.target == TGT_RAM_READ ||
                          out_result_reg.target == TGT_RAM_WRITE),
        out_result_reg.mapped_address[20:15] == 6'd0,
        "ram address outside ram banks")

    // banking state only changes when an access leaves the input register
    `CBC_ASSERT_NXT(a_state_hold, clk, rst_n, !s1_fire, $stable(state),
        "bank state changed without an access")

endmodule

// ----- rtl/cbc_translate.sv -----
// address decode, bank register update and physical address translation
module cbc_translate
    import cbc_pkg::*;
(
    input  logic        command,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  cbc_state_t  state,
    output cbc_state_t  state_next,
    output cbc_result_t result
);

    logic in_rom;
    logic in_ram;

    always_comb
    begin
        in_rom = (address >= ROM_WIN_LO) && (address <= ROM_WIN_HI);
        in_ram = (address >= RAM_WIN_LO) && (address <= RAM_WIN_HI);
        state_next = state;
        result = '0;
        result.target = TGT_NONE;
        if (!command)
        begin
            if (in_rom)
            begin
                result.handled = 1'b1;
                result.target = TGT_ROM_READ;
                result.mapped_address = {state.rom_bank, address[13:0]};
            end
            else if (in_ram)
            begin
                result.handled = 1'b1;
                result.target = TGT_RAM_READ;
                result.mapped_address = {6'd0, state.ram_bank, address[12:0]};
            end
        end
        else
        begin
            if (address <= ROM_WIN_HI)
            begin
                result.handled = 1'b1;
                result.target = TGT_CONTROL;
                if (address < CTRL_STRIDE)
                begin
                    state_next.ram_enable = (write_data[3:0] == RAM_EN_KEY);
                end
                else if (address < ROM_WIN_LO)
                begin
                    state_next.rom_bank = adjust_bank({state.rom_bank[6:5], write_data[4:0]});
                end
                else if (address < (ROM_WIN_LO + CTRL_STRIDE))
                begin
                    if (state.ram_mode)
                    begin
                        state_next.ram_bank = write_data[1:0];
                    end
                    else
                    begin
                        state_next.rom_bank =
                            adjust_bank({write_data[1:0], state.rom_bank[4:0]});
                    end
                end
                else
                begin
                    state_next.ram_mode = write_data[0];
                end
            end
            else if (in_ram)
            begin
                result.handled = 1'b1;
                result.target = TGT_RAM_WRITE;
                result.mapped_address = {6'd0, state.ram_bank, address[12:0]};
                result.ram_data_out = write_data;
            end
        end
        result.ram_enable_flag = state_next.ram_enable;
    end

endmodule

// ----- rtl/cbc_bank_regs.sv -----
// banking state registers with reset values
module cbc_bank_regs
    import cbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  cbc_state_t state_next,
    output cbc_state_t state
);

    cbc_state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.rom_bank   <= 7'd1;
            state_reg.ram_bank   <= 2'd0;
            state_reg.ram_mode   <= 1'b0;
            state_reg.ram_enable <= 1'b0;
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- sim/cbc_result_checker.sv -----
// predictor and result check for the cartridge bank controller testbench
module cbc_result_checker
    import cbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    cbc_access_if   access,
    cbc_result_if   result,
    output int      fail_count,
    output int      pending_count
);

    localparam int PRINT_LIMIT = 40;

    // banking state as the block should hold it
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_mode;
    logic       ram_enabled;

    cbc_result_t expected_results[$];

    function automatic logic [6:0] skip_zero_bank(input logic [6:0] b);
        if (b == 7'h00 || b == 7'h20 || b == 7'h40 || b == 7'h60)
        begin
            return b + 7'd1;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("%0t: mismatch: %s", $time, msg);
        end
        fail_count = fail_count + 1;
    endtask

    // translate one bus access and update the banking state
    task automatic translate_access(input logic is_write, input logic [15:0] addr,
                                    input logic [7:0] data, output cbc_result_t r);
        r = '0;
        r.target = TGT_NONE;
        if (!is_write)
        begin
            if (addr >= ROM_WIN_LO && addr <= ROM_WIN_HI)
            begin
                r.handled = 1'b1;
                r.target = TGT_ROM_READ;
                r.mapped_address = 21'(rom_bank) * 21'h4000 + 21'(addr - ROM_WIN_LO);
            end
            else if (addr >= RAM_WIN_LO && addr <= RAM_WIN_HI)
            begin
                r.handled = 1'b1;
                r.target = TGT_RAM_READ;
                r.mapped_address = 21'(ram_bank) * 21'h2000 + 21'(addr - RAM_WIN_LO);
            end
        end
        else if (addr <= ROM_WIN_HI)
        begin
            r.handled = 1'b1;
            r.target = TGT_CONTROL;
            if (addr < CTRL_STRIDE)
            begin
                ram_enabled = (data[3:0] == RAM_EN_KEY);
            end
            else if (addr < ROM_WIN_LO)
            begin
                rom_bank = skip_zero_bank((rom_bank & 7'h60) + 7'(data[4:0]));
            end
            else if (addr < ROM_WIN_LO + CTRL_STRIDE)
            begin
                if (ram_mode)
                begin
                    ram_bank = data[1:0];
                end
                else
                begin
                    rom_bank = skip_zero_bank((rom_bank & 7'h1F) + {data[1:0], 5'd0});
                end
            end
            else
            begin
                ram_mode = data[0];
            end
        end
        else if (addr >= RAM_WIN_LO && addr <= RAM_WIN_HI)
        begin
            r.handled = 1'b1;
            r.target = TGT_RAM_WRITE;
            r.mapped_address = 21'(ram_bank) * 21'h2000 + 21'(addr - RAM_WIN_LO);
            r.ram_data_out = data;
        end
        r.ram_enable_flag = ram_enabled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cbc_result_t want;
        cbc_result_t next_result;
        if (!rst_n)
        begin
            rom_bank = 7'd1;
            ram_bank = 2'd0;
            ram_mode = 1'b0;
            ram_enabled = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result transfer with no access pending (target %0d)",
                                              result.target));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.handled !== want.handled)
                        report_mismatch($sformatf("handled %b, expected %b",
                                                  result.handled, want.handled));
                    if (result.target !== want.target)
                        report_mismatch($sformatf("target %0d, expected %0d",
                                                  result.target, want.target));
                    if (result.mapped_address !== want.mapped_address)
                        report_mismatch($sformatf("mapped_address %h, expected %h",
                                                  result.mapped_address, want.mapped_address));
                    if (result.ram_data_out !== want.ram_data_out)
                        report_mismatch($sformatf("ram_data_out %h, expected %h",
                                                  result.ram_data_out, want.ram_data_out));
                    if (result.ram_enable_flag !== want.ram_enable_flag)
                        report_mismatch($sformatf("ram_enable_flag %b, expected %b",
                                                  result.ram_enable_flag, want.ram_enable_flag));
                end
            end
            if (access.valid && access.ready)
            begin
                translate_access(access.command, access.address, access.write_data, next_result);
                expected_results.push_back(next_result);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ----- sim/cartridge_bank_controller_tb.sv -----
// testbench top: bus access stimulus, result stalls and final verdict
module cartridge_bank_controller_tb
    import cbc_pkg::*;
();

    localparam logic CMD_READ     = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;
    localparam int   RANDOM_ITEMS = 850;
    localparam int   CYCLE_LIMIT  = 200000;
    // the block answers through its input and result registers, so a short drain is plenty
    localparam int   DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    // accesses left in the current sender burst
    int   burst_left = 0;

    cbc_access_if access_ch();
    cbc_result_if result_ch();

    cartridge_bank_controller dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_ch),
        .result (result_ch)
    );

    // watches both channels, predicts every result and counts mismatches
    cbc_result_checker result_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .access        (access_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs or drops results
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cartridge_bank_controller_tb NOT OK");
            $finish;
        end
    end

    // one access on the bus; entered and left at a falling edge
    task automatic issue_access(input logic cmd, input logic [15:0] addr,
                                input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            // a quarter of bursts follow the last one back to back
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                access_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        access_ch.valid = 1'b1;
        access_ch.command = cmd;
        access_ch.address = addr;
        access_ch.write_data = data;
        // hold until the transfer takes place
        @(posedge clk);
        while (!access_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left = burst_left - 1;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_all_results();
        access_ch.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // result side: stalls on its own pattern of modes, independent of the sender
    initial
    begin
        int mode;
        int span;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            if (mode == 3)
            begin
                // one long stall then a single transfer slot
                result_ch.ready = 1'b0;
                repeat ($urandom_range(5, 30)) @(negedge clk);
                result_ch.ready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                repeat (span)
                begin
                    @(negedge clk);
                    case (mode)
                        0: result_ch.ready = 1'b1;
                        1: result_ch.ready = 1'($urandom_range(0, 1));
                        default: result_ch.ready = ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        int          sent;
        int          kind;
        int          window;
        int          follow;
        bit          paused;
        logic [15:0] addr;
        logic [7:0]  data;

        rst_n = 1'b0;
        access_ch.valid = 1'b0;
        access_ch.command = CMD_READ;
        access_ch.address = 16'h0000;
        access_ch.write_data = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: window edges, latch key, bank zero stepping, both modes
        issue_access(CMD_READ,  16'h0000, 8'h00);   // fixed rom bank, not ours
        issue_access(CMD_READ,  16'h3FFF, 8'hFF);
        issue_access(CMD_READ,  16'h4000, 8'h00);   // bank 1 after reset
        issue_access(CMD_READ,  16'h7FFF, 8'h00);
        issue_access(CMD_READ,  16'h8000, 8'h00);   // video memory, unhandled
        issue_access(CMD_READ,  16'hA000, 8'h00);   // ram read while latch is off
        issue_access(CMD_READ,  16'hFFFF, 8'h00);
        issue_access(CMD_WRITE, 16'h0000, 8'h0A);   // enable key
        issue_access(CMD_WRITE, 16'h1FFF, 8'hF5);   // not the key, disables
        issue_access(CMD_WRITE, 16'h1000, 8'hFA);   // key in the low nibble only
        issue_access(CMD_WRITE, 16'h2000, 8'h00);   // bank zero steps to one
        issue_access(CMD_WRITE, 16'h3FFF, 8'hFF);   // low bits all set
        issue_access(CMD_WRITE, 16'h4000, 8'h03);   // high bits in rom mode, bank 0x7F
        issue_access(CMD_READ,  16'h7FFF, 8'h00);   // top of the physical rom
        issue_access(CMD_WRITE, 16'h2000, 8'hE0);   // bank 0x60 steps to 0x61
        issue_access(CMD_READ,  16'h4000, 8'h00);
        issue_access(CMD_WRITE, 16'h6000, 8'h01);   // ram banking mode
        issue_access(CMD_WRITE, 16'h5FFF, 8'hFF);   // ram bank 3
        issue_access(CMD_WRITE, 16'hBFFF, 8'hFF);   // ram write at the window top
        issue_access(CMD_WRITE, 16'h7FFF, 8'hFE);   // back to rom mode
        issue_access(CMD_READ,  16'hA000, 8'h00);   // ram bank kept in rom mode
        issue_access(CMD_WRITE, 16'hA000, 8'h00);
        issue_access(CMD_WRITE, 16'h8000, 8'h55);   // writes outside every window
        issue_access(CMD_WRITE, 16'hFFFF, 8'hAA);
        issue_access(CMD_WRITE, 16'h4000, 8'h00);   // high bits cleared, bank 0x01
        issue_access(CMD_READ,  16'h5555, 8'h00);

        // random: mostly a control write followed by accesses that use it
        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                // let the pipeline run dry once mid-run
                wait_all_results();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                window = $urandom_range(0, 3);
                addr = 16'(window) * CTRL_STRIDE + 16'($urandom_range(0, 16'h1FFF));
                data = 8'($urandom);
                if ($urandom_range(0, 2) == 0)
                begin
                    if (window == 0)
                        data[3:0] = RAM_EN_KEY;
                    else
                        data[4:0] = 5'd0;
                end
                issue_access(CMD_WRITE, addr, data);
                sent = sent + 1;
                follow = $urandom_range(1, 4);
                repeat (follow)
                begin
                    addr = 16'($urandom);
                    data = 8'($urandom);
                    case ($urandom_range(0, 2))
                        0: issue_access(CMD_READ, ROM_WIN_LO | {2'b00, addr[13:0]}, data);
                        1: issue_access(CMD_READ, RAM_WIN_LO | {3'b000, addr[12:0]}, data);
                        default: issue_access(CMD_WRITE, RAM_WIN_LO | {3'b000, addr[12:0]},
                                              data);
                    endcase
                    sent = sent + 1;
                end
            end
            else if (kind <= 8)
            begin
                // noise over the whole map
                issue_access(1'($urandom), 16'($urandom), 8'($urandom));
                sent = sent + 1;
            end
            else
            begin
                // accesses the controller must leave alone
                addr = 16'($urandom);
                case ($urandom_range(0, 2))
                    0: issue_access(CMD_READ, {2'b00, addr[13:0]}, 8'($urandom));
                    1: issue_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                                    {3'b100, addr[12:0]}, 8'($urandom));
                    default: issue_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                                          {2'b11, addr[13:0]}, 8'($urandom));
                endcase
                sent = sent + 1;
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("cartridge_bank_controller_tb OK");
        end
        else
        begin
            $display("cartridge_bank_controller_tb NOT OK");
        end
        $finish;
    end

endmodule
